// ===== hdl/rftq_pkg.sv =====
// Shared types and constants for the reliable frame transmit queue.
package rftq_pkg;

	typedef enum logic [1:0] {
		OP_ENQUEUE  = 2'd0,
		OP_ACK      = 2'd1,
		OP_POLL_PLN = 2'd2,
		OP_POLL_REL = 2'd3
	} op_t;

	localparam logic [1:0] FT_ACK      = 2'd0;
	localparam logic [1:0] FT_DATA     = 2'd1;
	localparam logic [1:0] FT_LOW_LAT  = 2'd2;
	localparam logic [1:0] FT_DATA_ACK = 2'd3;

	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	// Metadata kept per slot.
	typedef struct packed {
		logic        wait_ack;
		logic [7:0]  left;
		logic [4:0]  len;
		logic [7:0]  seq;
		logic [1:0]  ftype;
	} meta_t;

	// One slot as stored in a ring memory.
	typedef struct packed {
		meta_t       meta;
		logic [31:0] stamp;
		logic [63:0] lo;
		logic [63:0] hi;
	} slot_t;

	// Write request into a ring memory.
	typedef struct packed {
		logic        we;
		slot_t       data;
	} slot_wr_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_OUT  = 2'd2
	} state_t;

	// Byte mask of the low n bytes of a 64-bit word.
	function automatic logic [63:0] byte_mask(input logic [4:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (5'(i) < n) m[i*8 +: 8] = 8'hFF;
		end
		return m;
	endfunction

endpackage

// ===== hdl/rftq_ring_mem.sv =====
// Slot memory of one ring with a registered read port and one write port.
module rftq_ring_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic              clk,
	input  logic [AW-1:0]     raddr,
	output rftq_pkg::slot_t   rdata,
	input  logic [AW-1:0]     waddr,
	input  rftq_pkg::slot_wr_t wr
);

	rftq_pkg::slot_t mem [DEPTH];

	// Synchronous write and read.
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[waddr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/reliable_frame_tx_queue_core.sv =====
// Top level: two slot rings, sequence counters and the item sequencer.
// The head slot is read at the edge that takes a request; the next cycle
// modifies and writes back the slot and registers the result.
// A new request is taken only once the result is handed off and the sequencer idles;
// a stalled result holds off the input for as long as it waits.
// Reset clears ring pointers, fill counts, sequence counters and sets the ack
// timeout to 100; slot memories are not cleared and are read only when occupied.
module reliable_frame_tx_queue_core #(
	parameter int QUEUE_DEPTH = 32,
	parameter int MAX_PAYLOAD = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [1:0]  frame_type,
	input  logic [4:0]  payload_length,
	input  logic [63:0] payload_low,
	input  logic [63:0] payload_high,
	input  logic [7:0]  retry_limit,
	input  logic [7:0]  ack_sequence,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic        frame_valid,
	output logic [1:0]  out_frame_type,
	output logic [7:0]  out_sequence,
	output logic [4:0]  out_length,
	output logic [63:0] out_payload_low,
	output logic [63:0] out_payload_high,
	output logic        ack_matched,
	output logic        gave_up,
	output logic [5:0]  plain_fill,
	output logic [5:0]  reliable_fill
);

	localparam int AW = (QUEUE_DEPTH <= 2) ? 1 : $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
	localparam logic [4:0]    MAXP = 5'(MAX_PAYLOAD);

	rftq_pkg::state_t state_q, state_d;
	logic [15:0]   timeout_q;
	logic [AW-1:0] p_head_q, p_tail_q, r_head_q, r_tail_q;
	logic [CW-1:0] p_cnt_q, r_cnt_q;
	logic [7:0]    seq_q [4];

	// Captured request.
	rftq_pkg::op_t op_q;
	logic [1:0]  type_q;
	logic [4:0]  len_q;
	logic [63:0] lo_q, hi_q;
	logic [7:0]  retry_q, ackseq_q;
	logic [31:0] now_q;

	rftq_pkg::slot_t    p_rd, r_rd;
	rftq_pkg::slot_wr_t p_wr, r_wr;
	logic [AW-1:0]      p_waddr, r_waddr;

	// Result registers.
	logic        acc_q, fv_q, am_q, gu_q;
	logic [1:0]  oft_q;
	logic [7:0]  osq_q;
	logic [4:0]  olen_q;
	logic [63:0] olo_q, ohi_q;

	logic take;
	assign take = in_valid && !in_stall;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
		return (i == LAST) ? '0 : i + AW'(1);
	endfunction
	function automatic logic [AW-1:0] prv(input logic [AW-1:0] i);
		return (i == '0) ? LAST : i - AW'(1);
	endfunction

	rftq_ring_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_plain (
		.clk(clk), .raddr(p_head_q), .rdata(p_rd), .waddr(p_waddr), .wr(p_wr)
	);
	rftq_ring_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_rel (
		.clk(clk), .raddr(r_head_q), .rdata(r_rd), .waddr(r_waddr), .wr(r_wr)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rftq_pkg::ST_IDLE: if (take) state_d = rftq_pkg::ST_EXEC;
			rftq_pkg::ST_EXEC: state_d = rftq_pkg::ST_OUT;
			rftq_pkg::ST_OUT:  if (!out_stall) state_d = rftq_pkg::ST_IDLE;
			default:           state_d = rftq_pkg::ST_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		in_stall  = (state_q != rftq_pkg::ST_IDLE);
		out_valid = (state_q == rftq_pkg::ST_OUT);
	end

	// Execute stage decode: memory data of the head is valid in ST_EXEC.
	logic        exec;
	logic        rel_t, full, elapsed_gt;
	logic [4:0]  len_c;
	logic [7:0]  retry_c, left_m1;
	logic [31:0] elapsed;
	rftq_pkg::slot_t new_slot;

	always_comb begin
		exec    = (state_q == rftq_pkg::ST_EXEC);
		rel_t   = type_q[1];
		full    = rel_t ? (r_cnt_q == FULL) : (p_cnt_q == FULL);
		len_c   = (len_q > MAXP) ? MAXP : len_q;
		retry_c = (retry_q == '0) ? 8'd1 : retry_q;
		elapsed = now_q - r_rd.stamp;
		elapsed_gt = elapsed > {16'd0, timeout_q};
		left_m1 = r_rd.meta.left - 8'd1;
		new_slot.meta.wait_ack = 1'b0;
		new_slot.meta.left  = retry_c;
		new_slot.meta.len   = len_c;
		new_slot.meta.seq   = seq_q[type_q];
		new_slot.meta.ftype = type_q;
		new_slot.stamp = '0;
		new_slot.lo = lo_q & rftq_pkg::byte_mask(len_c);
		new_slot.hi = (len_c > 5'd8) ? (hi_q & rftq_pkg::byte_mask(len_c - 5'd8)) : '0;
	end

	// Memory write requests.
	always_comb begin
		p_wr    = '0;
		r_wr    = '0;
		p_waddr = p_tail_q;
		r_waddr = r_head_q;
		if (exec) begin
			unique case (op_q)
				rftq_pkg::OP_ENQUEUE: begin
					if (!full) begin
						if (rel_t) begin
							r_wr.we   = 1'b1;
							r_wr.data = new_slot;
							r_waddr   = (type_q == rftq_pkg::FT_LOW_LAT) ? prv(r_head_q)
								: r_tail_q;
						end else begin
							p_wr.we   = 1'b1;
							p_wr.data = new_slot;
						end
					end
				end
				rftq_pkg::OP_POLL_REL: begin
					if (r_cnt_q != '0) begin
						r_wr.data = r_rd;
						r_wr.data.stamp = now_q;
						if (!r_rd.meta.wait_ack) begin
							r_wr.we = 1'b1;
							r_wr.data.meta.wait_ack = 1'b1;
						end else if (elapsed_gt && left_m1 != '0) begin
							r_wr.we = 1'b1;
							r_wr.data.meta.left = left_m1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Control state and results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rftq_pkg::ST_IDLE;
			timeout_q <= rftq_pkg::TIMEOUT_RESET;
			p_head_q  <= '0;
			p_tail_q  <= '0;
			r_head_q  <= '0;
			r_tail_q  <= '0;
			p_cnt_q   <= '0;
			r_cnt_q   <= '0;
			for (int i = 0; i < 4; i++) seq_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) timeout_q <= cfg_wdata;
			if (exec) begin
				unique case (op_q)
					rftq_pkg::OP_ENQUEUE: begin
						if (!full) begin
							seq_q[type_q] <= seq_q[type_q] + 8'd1;
							if (rel_t) begin
								r_cnt_q <= r_cnt_q + CW'(1);
								if (type_q == rftq_pkg::FT_LOW_LAT) r_head_q <= prv(r_head_q);
								else r_tail_q <= nxt(r_tail_q);
							end else begin
								p_cnt_q  <= p_cnt_q + CW'(1);
								p_tail_q <= nxt(p_tail_q);
							end
						end
					end
					rftq_pkg::OP_ACK: begin
						if (r_cnt_q != '0 && r_rd.meta.seq == ackseq_q) begin
							r_head_q <= nxt(r_head_q);
							r_cnt_q  <= r_cnt_q - CW'(1);
						end
					end
					rftq_pkg::OP_POLL_PLN: begin
						if (p_cnt_q != '0) begin
							p_head_q <= nxt(p_head_q);
							p_cnt_q  <= p_cnt_q - CW'(1);
						end
					end
					rftq_pkg::OP_POLL_REL: begin
						if (r_cnt_q != '0 && r_rd.meta.wait_ack && elapsed_gt
							&& left_m1 == '0) begin
							r_head_q <= nxt(r_head_q);
							r_cnt_q  <= r_cnt_q - CW'(1);
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Request capture and result payload.
	always_ff @(posedge clk) begin
		if (take) begin
			op_q     <= rftq_pkg::op_t'(operation);
			type_q   <= frame_type;
			len_q    <= payload_length;
			lo_q     <= payload_low;
			hi_q     <= payload_high;
			retry_q  <= retry_limit;
			ackseq_q <= ack_sequence;
			now_q    <= now_ms;
		end
		if (exec) begin
			acc_q <= 1'b0; fv_q <= 1'b0; am_q <= 1'b0; gu_q <= 1'b0;
			oft_q <= '0; osq_q <= '0; olen_q <= '0; olo_q <= '0; ohi_q <= '0;
			unique case (op_q)
				rftq_pkg::OP_ENQUEUE: if (!full) begin
					acc_q <= 1'b1;
					osq_q <= seq_q[type_q];
				end
				rftq_pkg::OP_ACK:
					am_q <= (r_cnt_q != '0) && (r_rd.meta.seq == ackseq_q);
				rftq_pkg::OP_POLL_PLN: if (p_cnt_q != '0) begin
					fv_q <= 1'b1; oft_q <= p_rd.meta.ftype; osq_q <= p_rd.meta.seq;
					olen_q <= p_rd.meta.len; olo_q <= p_rd.lo; ohi_q <= p_rd.hi;
				end
				rftq_pkg::OP_POLL_REL: if (r_cnt_q != '0) begin
					if (!r_rd.meta.wait_ack || (elapsed_gt && left_m1 != '0)) begin
						fv_q <= 1'b1; oft_q <= r_rd.meta.ftype; osq_q <= r_rd.meta.seq;
						olen_q <= r_rd.meta.len; olo_q <= r_rd.lo; ohi_q <= r_rd.hi;
					end else if (elapsed_gt) begin
						gu_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign accepted         = acc_q;
	assign frame_valid      = fv_q;
	assign out_frame_type   = oft_q;
	assign out_sequence     = osq_q;
	assign out_length       = olen_q;
	assign out_payload_low  = olo_q;
	assign out_payload_high = ohi_q;
	assign ack_matched      = am_q;
	assign gave_up          = gu_q;
	assign plain_fill       = 6'(p_cnt_q);
	assign reliable_fill    = 6'(r_cnt_q);

	// A result never flags both a sent frame and a dropped head.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_valid && gave_up)) else $error("emit and give up together");
	// Fill counts never exceed the ring depth.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(p_cnt_q <= FULL) && (r_cnt_q <= FULL)) else $error("fill count overflow");
	// The input is held off while an item is in flight.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");

endmodule
